@@ hdl/double_ended_bump_allocator_core_assert.svh @@
// Assertion helpers used by the allocator core RTL.
`ifndef DOUBLE_ENDED_BUMP_ALLOCATOR_CORE_ASSERT_SVH
`define DOUBLE_ENDED_BUMP_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEBUMP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define DEBUMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed in the following cycle");

`endif

@@ hdl/debump_pkg.sv @@
`default_nettype none

package debump_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ALIGN_W = 18;
    localparam int unsigned INDEX_W = 2;

    // Smallest allocation unit and alignment, in bytes.
    localparam logic [WORD_W-1:0]  MIN_UNIT       = 32'd4;
    localparam logic [ALIGN_W-1:0] MIN_ALIGN      = 18'd4;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE_ALL  = 2'd1,
        OP_FREE_TAIL = 2'd2,
        OP_QUERY     = 2'd3
    } op_t;

    typedef enum logic [INDEX_W-1:0] {
        CFG_REGION_BASE  = 2'd0,
        CFG_REGION_BYTES = 2'd1,
        CFG_ERROR_ENABLE = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    // Allocator state.
    typedef struct packed {
        word_t head;
        word_t tail;
        word_t free;
    } heap_state_t;

    // Item after input registration, with the state-independent work done.
    typedef struct packed {
        op_t                op;
        word_t              size;
        logic [ALIGN_W-1:0] align_m1;
        logic               from_tail;
    } prep_item_t;

    typedef struct packed {
        word_t block_address;
        logic  granted;
        logic  error_request;
    } alloc_result_t;

endpackage

`default_nettype wire

@@ hdl/debump_step.sv @@
`default_nettype none

module debump_step (
    input  wire debump_pkg::prep_item_t    item,
    input  wire debump_pkg::heap_state_t   state,
    input  wire debump_pkg::word_t         region_base,
    input  wire debump_pkg::word_t         region_bytes,
    input  wire logic                      error_enable,
    output debump_pkg::heap_state_t        state_next,
    output debump_pkg::alloc_result_t      result
);
    import debump_pkg::*;

    word_t mask;
    word_t head_start;
    word_t head_total;
    word_t tail_start;
    word_t tail_total;
    word_t region_end;
    logic  head_fits;
    logic  tail_fits;

    always_comb
    begin
        mask       = {{(WORD_W-ALIGN_W){1'b0}}, item.align_m1};
        region_end = region_base + region_bytes;
        head_start = (state.head + mask) & ~mask;
        head_total = item.size + (head_start - state.head);
        tail_start = (state.tail - item.size) & ~mask;
        tail_total = state.tail - tail_start;
        head_fits  = head_total <= state.free;
        tail_fits  = tail_total <= state.free;
    end

    always_comb
    begin
        state_next = state;
        result     = '0;
        case (item.op)
            OP_ALLOC:
            begin
                if (!item.from_tail)
                begin
                    if (head_fits)
                    begin
                        result.block_address = head_start;
                        result.granted       = 1'b1;
                        state_next.head      = head_start + item.size;
                        state_next.free      = state.free - head_total;
                    end
                    else
                    begin
                        result.error_request = error_enable;
                    end
                end
                else
                begin
                    if (tail_fits)
                    begin
                        result.block_address = tail_start;
                        result.granted       = 1'b1;
                        state_next.tail      = tail_start;
                        state_next.free      = state.free - tail_total;
                    end
                    else
                    begin
                        result.error_request = error_enable;
                    end
                end
            end
            OP_FREE_ALL:
            begin
                state_next.free = region_bytes;
                state_next.head = region_base;
                state_next.tail = region_end;
            end
            OP_FREE_TAIL:
            begin
                state_next.free = (region_end - state.tail) + state.free;
                state_next.tail = region_end;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/double_ended_bump_allocator_core.sv @@
// Double-ended bump allocator over one memory region.
// Configuration: write region_base, region_bytes and error_request_enable through the
// cfg channel (cfg_ready is always high), then send a free-all item to load the pointers.
// Request channel: req_valid with operation, request_bytes and align_dir; the item is
// taken at an edge where req_valid is high and req_stall is low.
// Response channel: rsp_valid with block_address, granted, error_request, free_bytes and
// head_address; the item leaves at an edge where rsp_valid is high and rsp_stall is low.
// From acceptance an item goes through the input register, then the pointer update and
// the response register. One item is taken every cycle while req_stall is low; the
// rate is set by the single pass of add, mask and compare against the pointer registers.
// When rsp_stall is high the response holds, the input register keeps one item and
// req_stall rises only once both are full.
// Reset clears the configuration, the pointers and the free count to zero and empties
// both registers; until a free-all item arrives the zero state is used as it stands.
`default_nettype none

module double_ended_bump_allocator_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [debump_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                 cfg_data,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic [1:0]                  operation,
    input  wire logic [31:0]                 request_bytes,
    input  wire logic signed [17:0]          align_dir,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output logic [31:0]                      block_address,
    output logic                             granted,
    output logic                             error_request,
    output logic [31:0]                      free_bytes,
    output logic [31:0]                      head_address
);
    import debump_pkg::*;

    `include "double_ended_bump_allocator_core_assert.svh"

    word_t         base_reg;
    word_t         bytes_reg;
    logic          err_en_reg;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    prep_item_t    s1_item_reg;
    prep_item_t    s1_item_next;

    heap_state_t   state_reg;
    heap_state_t   state_next;
    alloc_result_t step_result;

    logic          out_valid_reg;
    logic          out_valid_next;
    alloc_result_t out_result_reg;
    heap_state_t   out_state_reg;

    logic          req_accept;
    logic          advance;
    logic          s1_fire;

    word_t              size_min;
    logic [ALIGN_W-1:0] align_mag;
    logic [ALIGN_W-1:0] align_val;

    assign cfg_ready  = 1'b1;
    assign advance    = !out_valid_reg || !rsp_stall;
    assign s1_fire    = s1_valid_reg && advance;
    assign req_stall  = s1_valid_reg && !advance;
    assign req_accept = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            bytes_reg  <= '0;
            err_en_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_REGION_BASE:  base_reg   <= cfg_data;
                CFG_REGION_BYTES: bytes_reg  <= cfg_data;
                CFG_ERROR_ENABLE: err_en_reg <= cfg_data[0];
                default:          err_en_reg <= err_en_reg;
            endcase
        end
    end

    // Size rounding and the alignment mask do not depend on the state, so they are
    // worked out ahead of the input register.
    always_comb
    begin
        size_min                = (request_bytes < MIN_UNIT) ? MIN_UNIT : request_bytes;
        s1_item_next.op         = op_t'(operation);
        s1_item_next.size       = (size_min + (MIN_UNIT - 32'd1)) & ~(MIN_UNIT - 32'd1);
        s1_item_next.from_tail  = align_dir[ALIGN_W-1];
        align_mag               = align_dir[ALIGN_W-1] ? ALIGN_W'(18'd0 - align_dir)
                                                       : ALIGN_W'(align_dir);
        align_val               = (align_mag < MIN_ALIGN) ? MIN_ALIGN : align_mag;
        s1_item_next.align_m1   = align_val - 18'd1;
    end

    always_comb
    begin
        if (req_accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        if (s1_fire)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
            s1_item_reg <= s1_item_next;
        if (s1_fire)
        begin
            out_result_reg <= step_result;
            out_state_reg  <= state_next;
        end
    end

    debump_step u_step (
        .item         (s1_item_reg),
        .state        (state_reg),
        .region_base  (base_reg),
        .region_bytes (bytes_reg),
        .error_enable (err_en_reg),
        .state_next   (state_next),
        .result       (step_result)
    );

    assign rsp_valid     = out_valid_reg;
    assign block_address = out_result_reg.block_address;
    assign granted       = out_result_reg.granted;
    assign error_request = out_result_reg.error_request;
    assign free_bytes    = out_state_reg.free;
    assign head_address  = out_state_reg.head;

    // A grant and an error request never appear together.
    `DEBUMP_ASSERT_SAME(a_grant_err_excl, clk, rst_n, out_valid_reg, !(granted && error_request))
    // A response without a grant always carries a zero address.
    `DEBUMP_ASSERT_SAME(a_no_grant_zero, clk, rst_n, out_valid_reg && !granted,
        block_address == '0)
    // A refused allocation leaves the free count untouched.
    `DEBUMP_ASSERT_NEXT(a_fail_keeps_free, clk, rst_n,
        s1_fire && (s1_item_reg.op == OP_ALLOC) && !step_result.granted,
        state_reg.free == $past(state_reg.free))
    // An item leaving the input register always lands in the response register.
    `DEBUMP_ASSERT_NEXT(a_fire_fills_out, clk, rst_n, s1_fire, out_valid_reg)

endmodule

`default_nettype wire
